FILE: src/csvf_pkg.sv
`timescale 1ns / 1ps
package csvf_pkg;

   localparam int unsigned CSVF_STAGES = 2;

   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned COEF_W   = 16;
   localparam int unsigned STATE_W  = 24;
   localparam int unsigned ACC_W    = 32;
   localparam int unsigned GH_W     = 30;
   localparam int unsigned OPB_W    = 18;
   localparam int unsigned PROD_W   = ACC_W + OPB_W;
   localparam int unsigned WIDE_W   = 40;
   localparam int unsigned R12_W    = PROD_W - 12;
   localparam int unsigned R15_W    = PROD_W - 15;

   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = COEF_W;

   localparam logic [COEF_W-1:0] COEF_G_RESET  = 16'd1024;
   localparam logic [COEF_W-1:0] COEF_H_RESET  = 16'd32768;
   localparam logic [COEF_W-1:0] DAMPING_RESET = 16'd677;

   localparam int unsigned PC_W = 4;
   localparam logic [PC_W-1:0] UC_DONE = 4'd10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_G     = 2'd0,
      CSR_COEF_H     = 2'd1,
      CSR_DAMPING_R2 = 2'd2
   } csr_idx_type;

   typedef enum logic [2:0] {
      MUL_NONE  = 3'd0,
      MUL_S1_GR = 3'd1,
      MUL_A_H   = 3'd2,
      MUL_A_G   = 3'd3,
      MUL_BP_G  = 3'd4,
      MUL_BP_R2 = 3'd5
   } mul_sel_type;

   typedef enum logic [2:0] {
      ALU_NOP  = 3'd0,
      ALU_LOAD = 3'd1,
      ALU_DIFF = 3'd2,
      ALU_HP   = 3'd3,
      ALU_BP   = 3'd4,
      ALU_S1   = 3'd5,
      ALU_S2   = 3'd6,
      ALU_Y    = 3'd7
   } alu_op_type;

   typedef enum logic [1:0] {
      JMP_NEXT   = 2'd0,
      JMP_CLEAR  = 2'd1,
      JMP_LOOP   = 2'd2,
      JMP_FINISH = 2'd3
   } jmp_type;

   typedef struct packed {
      mul_sel_type mul;
      alu_op_type  alu;
      jmp_type     jmp;
   } ucode_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic finish;
      logic clr;
   } ctl_type;

   typedef struct packed {
      logic [COEF_W-1:0] g;
      logic [COEF_W-1:0] h;
      logic [COEF_W-1:0] r2;
   } coef_type;

   // floor(v / 4096 + 1/2)
   function automatic logic signed [R12_W-1:0] rnd12(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] w;
      w = v + PROD_W'(2048);
      return w[PROD_W-1:12];
   endfunction

   function automatic logic signed [R15_W-1:0] rnd15(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] w;
      w = v + PROD_W'(16384);
      return w[PROD_W-1:15];
   endfunction

   function automatic logic signed [STATE_W-1:0] sat24(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = 40'sd8388607;
      lo = -40'sd8388608;
      if (v > hi) begin
         return 24'sh7FFFFF;
      end else if (v < lo) begin
         return 24'sh800000;
      end
      return v[STATE_W-1:0];
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [STATE_W-1:0] v);
      logic signed [STATE_W-1:0] hi;
      logic signed [STATE_W-1:0] lo;
      hi = 24'sd32767;
      lo = -24'sd32768;
      if (v > hi) begin
         return 16'sh7FFF;
      end else if (v < lo) begin
         return 16'sh8000;
      end
      return v[SAMPLE_W-1:0];
   endfunction

endpackage

FILE: src/csvf_ifs.sv
`timescale 1ns / 1ps
interface csvf_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample_in;
   logic               clear;

   modport source(output valid, output sample_in, output clear, input ready);
   modport sink(input valid, input sample_in, input clear, output ready);
endinterface

interface csvf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] band_out;

   modport source(output valid, output band_out, input ready);
   modport sink(input valid, input band_out, output ready);
endinterface

FILE: src/cascaded_svf_bandpass_top.sv
`timescale 1ns / 1ps
// Cascade of STAGES identical state variable bandpass stages sharing coef_g, coef_h and
// damping_r2. A microcoded sequencer steps one shared 32x18 multiplier and a saturating
// adder through ten steps per stage; the multiplier is used five times per stage. A
// transaction with clear set zeroes all integrators and returns zero. A new transaction
// is taken once the previous one has left the sequencer, even while its result still
// waits on the response channel. Write coefficients only while idle.
module cascaded_svf_bandpass_top #(
   parameter int unsigned STAGES = csvf_pkg::CSVF_STAGES
) (
   input  logic                                clock,
   input  logic                                reset,
   csvf_req_if.sink                            req,
   csvf_rsp_if.source                          rsp,
   input  logic                                csr_wr_en,
   input  logic [csvf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [csvf_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import csvf_pkg::*;

   localparam int unsigned STG_W = (STAGES > 1) ? $clog2(STAGES) : 1;

   logic [COEF_W-1:0] coef_g_ff, coef_g_in;
   logic [COEF_W-1:0] coef_h_ff, coef_h_in;
   logic [COEF_W-1:0] damping_ff, damping_in;

   coef_type          coef;
   ctl_type           ctl;
   ucode_type         uword;
   logic [PC_W-1:0]   pc;
   logic [STG_W-1:0]  stage;
   logic              req_ready;
   logic              rsp_valid;
   logic signed [SAMPLE_W-1:0] band_out;

   always_comb begin
      coef_g_in  = coef_g_ff;
      coef_h_in  = coef_h_ff;
      damping_in = damping_ff;
      if (csr_wr_en) begin
         if (csr_index == CSR_COEF_G) begin
            coef_g_in = csr_wdata;
         end
         if (csr_index == CSR_COEF_H) begin
            coef_h_in = csr_wdata;
         end
         if (csr_index == CSR_DAMPING_R2) begin
            damping_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_g_ff  <= COEF_G_RESET;
         coef_h_ff  <= COEF_H_RESET;
         damping_ff <= DAMPING_RESET;
      end else begin
         coef_g_ff  <= coef_g_in;
         coef_h_ff  <= coef_h_in;
         damping_ff <= damping_in;
      end
   end

   assign coef = '{g: coef_g_ff, h: coef_h_ff, r2: damping_ff};

   assign req.ready    = req_ready;
   assign rsp.valid    = rsp_valid;
   assign rsp.band_out = band_out;

   csvf_ucode_rom u_rom (
      .pc    (pc),
      .uword (uword)
   );

   csvf_sequencer #(
      .STAGES (STAGES),
      .STG_W  (STG_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_clear (req.clear),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp.ready),
      .uword     (uword),
      .pc        (pc),
      .stage     (stage),
      .ctl       (ctl)
   );

   csvf_datapath #(
      .STAGES (STAGES),
      .STG_W  (STG_W)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .uword     (uword),
      .stage     (stage),
      .coef      (coef),
      .sample_in (req.sample_in),
      .band_out  (band_out)
   );

endmodule

FILE: src/csvf_ucode_rom.sv
`timescale 1ns / 1ps
module csvf_ucode_rom (
   input  logic [csvf_pkg::PC_W-1:0] pc,
   output csvf_pkg::ucode_type       uword
);
   import csvf_pkg::*;

   // one stage per pass of steps 0..9, step 10 hands off the result
   always_comb begin
      unique case (pc)
         4'd0:    uword = '{mul: MUL_NONE,  alu: ALU_LOAD, jmp: JMP_CLEAR};
         4'd1:    uword = '{mul: MUL_S1_GR, alu: ALU_NOP,  jmp: JMP_NEXT};
         4'd2:    uword = '{mul: MUL_NONE,  alu: ALU_DIFF, jmp: JMP_NEXT};
         4'd3:    uword = '{mul: MUL_A_H,   alu: ALU_NOP,  jmp: JMP_NEXT};
         4'd4:    uword = '{mul: MUL_NONE,  alu: ALU_HP,   jmp: JMP_NEXT};
         4'd5:    uword = '{mul: MUL_A_G,   alu: ALU_NOP,  jmp: JMP_NEXT};
         4'd6:    uword = '{mul: MUL_NONE,  alu: ALU_BP,   jmp: JMP_NEXT};
         4'd7:    uword = '{mul: MUL_BP_G,  alu: ALU_S1,   jmp: JMP_NEXT};
         4'd8:    uword = '{mul: MUL_BP_R2, alu: ALU_S2,   jmp: JMP_NEXT};
         4'd9:    uword = '{mul: MUL_NONE,  alu: ALU_Y,    jmp: JMP_LOOP};
         default: uword = '{mul: MUL_NONE,  alu: ALU_NOP,  jmp: JMP_FINISH};
      endcase
   end

endmodule

FILE: src/csvf_datapath.sv
`timescale 1ns / 1ps
module csvf_datapath #(
   parameter int unsigned STAGES = csvf_pkg::CSVF_STAGES,
   parameter int unsigned STG_W  = (STAGES > 1) ? $clog2(STAGES) : 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  csvf_pkg::ctl_type                     ctl,
   input  csvf_pkg::ucode_type                   uword,
   input  logic [STG_W-1:0]                      stage,
   input  csvf_pkg::coef_type                    coef,
   input  logic signed [csvf_pkg::SAMPLE_W-1:0]  sample_in,
   output logic signed [csvf_pkg::SAMPLE_W-1:0]  band_out
);
   import csvf_pkg::*;

   logic signed [STATE_W-1:0]  x_ff, x_in;
   logic signed [STATE_W-1:0]  s1_ff, s1_in;
   logic signed [STATE_W-1:0]  s2_ff, s2_in;
   logic signed [ACC_W-1:0]    a_ff, a_in;
   logic signed [GH_W-1:0]     gh_ff, gh_in;
   logic signed [STATE_W-1:0]  bp_ff, bp_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [SAMPLE_W-1:0] band_ff, band_in;
   logic signed [STATE_W-1:0]  st1_ff [STAGES];
   logic signed [STATE_W-1:0]  st1_in [STAGES];
   logic signed [STATE_W-1:0]  st2_ff [STAGES];
   logic signed [STATE_W-1:0]  st2_in [STAGES];

   logic signed [ACC_W-1:0]  op_a;
   logic signed [OPB_W-1:0]  op_b;
   logic                     mul_en;
   logic signed [R12_W-1:0]  r12;
   logic signed [R15_W-1:0]  r15;
   logic signed [STATE_W-1:0] hp;
   logic [COEF_W:0]          g_plus_r2;

   assign band_out  = band_ff;
   assign r12       = rnd12(prod_ff);
   assign r15       = rnd15(prod_ff);
   assign hp        = sat24(WIDE_W'(r15));
   assign g_plus_r2 = {1'b0, coef.g} + {1'b0, coef.r2};

   // single shared multiplier
   always_comb begin
      mul_en = ctl.busy;
      op_a   = a_ff;
      op_b   = '0;
      unique case (uword.mul)
         MUL_S1_GR: begin
            op_a = ACC_W'(s1_ff);
            op_b = OPB_W'({1'b0, g_plus_r2});
         end
         MUL_A_H: begin
            op_a = a_ff;
            op_b = OPB_W'({2'b00, coef.h});
         end
         MUL_A_G: begin
            op_a = a_ff;
            op_b = OPB_W'({2'b00, coef.g});
         end
         MUL_BP_G: begin
            op_a = ACC_W'(bp_ff);
            op_b = OPB_W'({2'b00, coef.g});
         end
         MUL_BP_R2: begin
            op_a = ACC_W'(bp_ff);
            op_b = OPB_W'({2'b00, coef.r2});
         end
         default: mul_en = 1'b0;
      endcase
      prod_in = mul_en ? op_a * op_b : prod_ff;
   end

   always_comb begin
      x_in    = x_ff;
      s1_in   = s1_ff;
      s2_in   = s2_ff;
      a_in    = a_ff;
      gh_in   = gh_ff;
      bp_in   = bp_ff;
      band_in = band_ff;
      st1_in  = st1_ff;
      st2_in  = st2_ff;
      if (ctl.start) begin
         x_in = STATE_W'(sample_in);
      end else if (ctl.busy) begin
         unique case (uword.alu)
            ALU_NOP: begin
            end
            ALU_LOAD: begin
               s1_in = st1_ff[stage];
               s2_in = st2_ff[stage];
            end
            ALU_DIFF: begin
               a_in = ACC_W'(WIDE_W'(x_ff) - WIDE_W'(r12) - WIDE_W'(s2_ff));
            end
            ALU_HP: begin
               a_in = ACC_W'(hp);
            end
            ALU_BP: begin
               gh_in = GH_W'(r12);
               bp_in = sat24(WIDE_W'(r12) + WIDE_W'(s1_ff));
            end
            ALU_S1: begin
               s1_in = sat24(WIDE_W'(gh_ff) + WIDE_W'(bp_ff));
            end
            ALU_S2: begin
               s2_in = sat24((WIDE_W'(r12) <<< 1) + WIDE_W'(s2_ff));
            end
            ALU_Y: begin
               x_in = sat24(WIDE_W'(r12));
               st1_in[stage] = s1_ff;
               st2_in[stage] = s2_ff;
            end
         endcase
      end
      if (ctl.finish) begin
         if (ctl.clr) begin
            band_in = '0;
            for (int i = 0; i < STAGES; i++) begin
               st1_in[i] = '0;
               st2_in[i] = '0;
            end
         end else begin
            band_in = sat16(x_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      s1_ff   <= s1_in;
      s2_ff   <= s2_in;
      a_ff    <= a_in;
      gh_ff   <= gh_in;
      bp_ff   <= bp_in;
      prod_ff <= prod_in;
      band_ff <= band_in;
   end

   // integrator states reset to zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) begin
            st1_ff[i] <= '0;
            st2_ff[i] <= '0;
         end
      end else begin
         st1_ff <= st1_in;
         st2_ff <= st2_in;
      end
   end

endmodule

FILE: src/csvf_sequencer.sv
`timescale 1ns / 1ps
module csvf_sequencer #(
   parameter int unsigned STAGES = csvf_pkg::CSVF_STAGES,
   parameter int unsigned STG_W  = (STAGES > 1) ? $clog2(STAGES) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_clear,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  csvf_pkg::ucode_type        uword,
   output logic [csvf_pkg::PC_W-1:0]  pc,
   output logic [STG_W-1:0]           stage,
   output csvf_pkg::ctl_type          ctl
);
   import csvf_pkg::*;

   logic              busy_ff, busy_in;
   logic              clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [STG_W-1:0]  k_ff, k_in;
   logic              start;
   logic              finish;
   logic              last_stage;

   assign req_ready  = !busy_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign pc         = pc_ff;
   assign stage      = k_ff;
   assign start      = req_valid && !busy_ff;
   assign last_stage = (k_ff == STG_W'(STAGES - 1));
   // the output register may be refilled in the cycle it is emptied
   assign finish     = busy_ff && (uword.jmp == JMP_FINISH) && (!rsp_valid_ff || rsp_ready);

   assign ctl = '{start: start, busy: busy_ff, finish: finish, clr: clr_ff};

   always_comb begin
      busy_in      = busy_ff;
      clr_in       = clr_ff;
      pc_in        = pc_ff;
      k_in         = k_ff;
      rsp_valid_in = finish || (rsp_valid_ff && !rsp_ready);
      if (start) begin
         busy_in = 1'b1;
         clr_in  = req_clear;
         pc_in   = '0;
         k_in    = '0;
      end else if (busy_ff) begin
         unique case (uword.jmp)
            JMP_NEXT: pc_in = pc_ff + 1'b1;
            JMP_CLEAR: pc_in = clr_ff ? UC_DONE : pc_ff + 1'b1;
            JMP_LOOP: begin
               if (last_stage) begin
                  pc_in = pc_ff + 1'b1;
               end else begin
                  pc_in = '0;
                  k_in  = k_ff + 1'b1;
               end
            end
            JMP_FINISH: begin
               if (finish) begin
                  busy_in = 1'b0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         clr_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
         k_ff         <= '0;
      end else begin
         busy_ff      <= busy_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         pc_ff        <= pc_in;
         k_ff         <= k_in;
      end
   end

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pc_ff <= UC_DONE))
      else $error("step counter ran past the program");

   a_stage_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (k_ff <= STG_W'(STAGES - 1)))
      else $error("stage index out of range");

   a_clear_short: assert property (@(posedge clock) disable iff (reset)
      (start && req_clear) |=> ##1 (pc_ff == UC_DONE))
      else $error("clear transaction did not skip the filter program");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while still held");

endmodule
